/* hdl/tcp_stream_reassembler_macros.svh */
// assertion helpers shared by the checker
`ifndef TCP_STREAM_REASSEMBLER_MACROS_SVH
`define TCP_STREAM_REASSEMBLER_MACROS_SVH

// same-cycle implication
`define TSR_ASSERT_IMPLY(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tsr check failed");

// next-cycle implication
`define TSR_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tsr check failed");

`endif

/* hdl/tsr_pkg.sv */
`default_nettype none

package tsr_pkg;

    // slot index width for the largest window
    localparam int SLOT_W = 6;
    localparam int LIM_W  = 7;
    localparam int GCNT_W = 4;

    typedef struct packed {
        logic              set_en;
        logic [SLOT_W-1:0] set_slot;
        logic              clr_en;
        logic [SLOT_W-1:0] clr_slot;
        logic              clr_all;
        logic              trim_en;
        logic [SLOT_W-1:0] trim_base;
        logic [LIM_W-1:0]  trim_lim;
    } t_valid_cmd;

endpackage

`default_nettype wire

/* hdl/tsr_byte_ram.sv */
`default_nettype none

module tsr_byte_ram #(
    parameter int WINDOW = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [$clog2(WINDOW)-1:0] i_waddr,
    input  wire logic [7:0]                i_wdata,
    input  wire logic                      i_re,
    input  wire logic [$clog2(WINDOW)-1:0] i_raddr,
    output logic      [7:0]                o_rdata
);

    logic [7:0] r_mem [WINDOW];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hdl/tsr_valid_store.sv */
`default_nettype none

module tsr_valid_store #(
    parameter int WINDOW = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire tsr_pkg::t_valid_cmd         i_cmd,
    output logic [WINDOW-1:0]                o_valid,
    output logic [tsr_pkg::GCNT_W-1:0]       o_grp_cnt [(WINDOW+7)/8]
);

    localparam int SW   = $clog2(WINDOW);
    localparam int NGRP = (WINDOW + 7) / 8;
    localparam int LW   = tsr_pkg::LIM_W;

    logic [WINDOW-1:0]           r_valid;
    logic [WINDOW-1:0]           n_valid;
    logic [WINDOW-1:0]           w_keep;
    logic [LW-1:0]               w_off [WINDOW];
    logic [LW-1:0]               w_base;
    logic [NGRP*8-1:0]           w_pad;
    logic [tsr_pkg::GCNT_W-1:0]  w_grp [NGRP];
    logic [tsr_pkg::GCNT_W-1:0]  r_grp [NGRP];

    assign w_base = LW'(i_cmd.trim_base[SW-1:0]);

    // keep a slot while its distance from the window base is below the limit
    always_comb begin
        for (int s = 0; s < WINDOW; s++) begin
            if (LW'(s) >= w_base) begin
                w_off[s] = LW'(s) - w_base;
            end else begin
                w_off[s] = LW'(s) + LW'(WINDOW) - w_base;
            end
            w_keep[s] = (w_off[s] < i_cmd.trim_lim);
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (i_cmd.trim_en) begin
            n_valid = r_valid & w_keep;
        end
        if (i_cmd.set_en) begin
            n_valid[i_cmd.set_slot[SW-1:0]] = 1'b1;
        end
        if (i_cmd.clr_en) begin
            n_valid[i_cmd.clr_slot[SW-1:0]] = 1'b0;
        end
        if (i_cmd.clr_all) begin
            n_valid = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // per-group occupancy, registered
    assign w_pad = (NGRP*8)'(r_valid);

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            w_grp[g] = '0;
            for (int b = 0; b < 8; b++) begin
                w_grp[g] = w_grp[g] + tsr_pkg::GCNT_W'(w_pad[g*8+b]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < NGRP; g++) begin
            r_grp[g] <= w_grp[g];
        end
    end

    assign o_valid   = r_valid;
    assign o_grp_cnt = r_grp;

endmodule

`default_nettype wire

/* hdl/tcp_stream_reassembler.sv */
// channel   handshake            payload
// request   start / busy         i_stream_index i_has_byte i_data_byte i_final_mark i_room
// result    o_strobe, one cycle  o_out_valid o_out_byte o_stream_closed o_run_last
//                                o_pending_count
//
// open-stream item: insert, scan, finish, close, emit per released byte; a final item first trims, waits, counts
// the valid-flag scan walks one slot per cycle and the byte ram gives one read per cycle
// an item arriving after close gives one status result and never leaves idle
// reset is synchronous and clears all valid flags at once, no clearing pass
// results leave as a back-to-back burst, the receiver cannot stall it
`default_nettype none

module tcp_stream_reassembler #(
    parameter int WINDOW = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] i_stream_index,
    input  wire logic        i_has_byte,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_final_mark,
    input  wire logic [6:0]  i_room,
    output logic             o_strobe,
    output logic             o_out_valid,
    output logic [7:0]       o_out_byte,
    output logic             o_stream_closed,
    output logic             o_run_last,
    output logic [6:0]       o_pending_count
);

    localparam int SW   = $clog2(WINDOW);
    localparam int CW   = $clog2(WINDOW + 1);
    localparam int NGRP = (WINDOW + 7) / 8;
    localparam int LW   = tsr_pkg::LIM_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISC = 4'd1;
    localparam logic [3:0] S_WAIT = 4'd2;
    localparam logic [3:0] S_CNT  = 4'd3;
    localparam logic [3:0] S_INS  = 4'd4;
    localparam logic [3:0] S_SCAN = 4'd5;
    localparam logic [3:0] S_FIN  = 4'd6;
    localparam logic [3:0] S_CLS  = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;

    logic [3:0]    r_state, n_state;
    logic [63:0]   r_idx, n_idx;
    logic          r_has, n_has;
    logic [7:0]    r_byte, n_byte;
    logic [CW-1:0] r_room, n_room;
    logic [63:0]   r_next, n_next;
    logic [63:0]   r_end, n_end;
    logic          r_end_known, n_end_known;
    logic          r_closed, n_closed;
    logic [CW-1:0] r_held, n_held;
    logic [SW-1:0] r_base, n_base;
    logic [SW-1:0] r_sptr, n_sptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_strobe, n_out_strobe;
    logic          r_out_mem, n_out_mem;
    logic          r_out_last, n_out_last;

    tsr_pkg::t_valid_cmd         w_cmd;
    logic [WINDOW-1:0]           w_valid;
    logic [tsr_pkg::GCNT_W-1:0]  w_grp [NGRP];
    logic [CW-1:0]               w_grp_sum;
    logic                        w_we;
    logic                        w_re;
    logic [7:0]                  w_rdata;
    logic [64:0]                 w_diff;
    logic [64:0]                 w_ediff;
    logic                        w_keep;
    logic [LW-1:0]               w_sum;
    logic [LW-1:0]               w_slot7;
    logic [SW-1:0]               w_slot;
    logic [LW-1:0]               w_lim;

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] x);
        slot_inc = (x == SW'(WINDOW - 1)) ? '0 : x + SW'(1);
    endfunction

    tsr_valid_store #(
        .WINDOW (WINDOW)
    ) u_valid (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_valid   (w_valid),
        .o_grp_cnt (w_grp)
    );

    tsr_byte_ram #(
        .WINDOW (WINDOW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_slot),
        .i_wdata (r_byte),
        .i_re    (w_re),
        .i_raddr (r_base),
        .o_rdata (w_rdata)
    );

    // acceptance window check and target slot
    assign w_diff  = {1'b0, r_idx} - {1'b0, r_next};
    assign w_keep  = r_has && !w_diff[64] && (w_diff[63:0] < 64'(r_room))
                     && (!r_end_known || (r_idx < r_end));
    assign w_sum   = LW'(r_base) + w_diff[LW-1:0];
    assign w_slot7 = (w_sum >= LW'(WINDOW)) ? w_sum - LW'(WINDOW) : w_sum;
    assign w_slot  = w_slot7[SW-1:0];

    // bytes kept after the end is learned
    assign w_ediff = {1'b0, r_end} - {1'b0, r_next};
    assign w_lim   = w_ediff[64] ? '0 :
                     (w_ediff[63:0] >= 64'(WINDOW)) ? LW'(WINDOW) : w_ediff[LW-1:0];

    always_comb begin
        w_grp_sum = '0;
        for (int g = 0; g < NGRP; g++) begin
            w_grp_sum = w_grp_sum + CW'(w_grp[g]);
        end
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_has        = r_has;
        n_byte       = r_byte;
        n_room       = r_room;
        n_next       = r_next;
        n_end        = r_end;
        n_end_known  = r_end_known;
        n_closed     = r_closed;
        n_held       = r_held;
        n_base       = r_base;
        n_sptr       = r_sptr;
        n_cnt        = r_cnt;
        n_out_strobe = 1'b0;
        n_out_mem    = 1'b0;
        n_out_last   = 1'b0;
        w_cmd        = '0;
        w_we         = 1'b0;
        w_re         = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (r_closed) begin
                        n_out_strobe = 1'b1;
                        n_out_last   = 1'b1;
                    end else begin
                        n_idx  = i_stream_index;
                        n_has  = i_has_byte;
                        n_byte = i_data_byte;
                        n_room = (i_room > 7'(WINDOW)) ? CW'(WINDOW) : i_room[CW-1:0];
                        if (i_final_mark) begin
                            n_end_known = 1'b1;
                            if (!i_has_byte || (&i_stream_index)) begin
                                n_end = i_stream_index;
                            end else begin
                                n_end = i_stream_index + 64'd1;
                            end
                            n_state = S_DISC;
                        end else begin
                            n_state = S_INS;
                        end
                    end
                end
            end
            S_DISC: begin
                w_cmd.trim_en   = 1'b1;
                w_cmd.trim_base = tsr_pkg::SLOT_W'(r_base);
                w_cmd.trim_lim  = w_lim;
                n_state         = S_WAIT;
            end
            S_WAIT: begin
                n_state = S_CNT;
            end
            S_CNT: begin
                n_held  = w_grp_sum;
                n_state = S_INS;
            end
            S_INS: begin
                if (w_keep && !w_valid[w_slot]) begin
                    w_we           = 1'b1;
                    w_cmd.set_en   = 1'b1;
                    w_cmd.set_slot = tsr_pkg::SLOT_W'(w_slot);
                    n_held         = r_held + CW'(1);
                end
                n_sptr  = r_base;
                n_cnt   = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if ((r_cnt < r_room) && w_valid[r_sptr]) begin
                    n_cnt  = r_cnt + CW'(1);
                    n_sptr = slot_inc(r_sptr);
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_next  = r_next + 64'(r_cnt);
                n_held  = r_held - r_cnt;
                n_state = S_CLS;
            end
            S_CLS: begin
                if (r_end_known && (r_next >= r_end)) begin
                    n_closed      = 1'b1;
                    n_held        = '0;
                    w_cmd.clr_all = 1'b1;
                end
                if (r_cnt == '0) begin
                    n_out_strobe = 1'b1;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                w_re           = 1'b1;
                w_cmd.clr_en   = 1'b1;
                w_cmd.clr_slot = tsr_pkg::SLOT_W'(r_base);
                n_base         = slot_inc(r_base);
                n_cnt          = r_cnt - CW'(1);
                n_out_strobe   = 1'b1;
                n_out_mem      = 1'b1;
                n_out_last     = (r_cnt == CW'(1));
                if (r_cnt == CW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_next       <= '0;
            r_end        <= '0;
            r_end_known  <= 1'b0;
            r_closed     <= 1'b0;
            r_held       <= '0;
            r_base       <= '0;
            r_sptr       <= '0;
            r_cnt        <= '0;
            r_out_strobe <= 1'b0;
            r_out_mem    <= 1'b0;
            r_out_last   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_next       <= n_next;
            r_end        <= n_end;
            r_end_known  <= n_end_known;
            r_closed     <= n_closed;
            r_held       <= n_held;
            r_base       <= n_base;
            r_sptr       <= n_sptr;
            r_cnt        <= n_cnt;
            r_out_strobe <= n_out_strobe;
            r_out_mem    <= n_out_mem;
            r_out_last   <= n_out_last;
        end
    end

    // request payload
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_has  <= n_has;
        r_byte <= n_byte;
        r_room <= n_room;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_strobe        = r_out_strobe;
    assign o_out_valid     = r_out_mem;
    assign o_out_byte      = r_out_mem ? w_rdata : 8'd0;
    assign o_stream_closed = r_closed;
    assign o_run_last      = r_out_last;
    assign o_pending_count = 7'(r_held);

endmodule

`default_nettype wire

/* hdl/tsr_checker.sv */
`default_nettype none
`include "tcp_stream_reassembler_macros.svh"

module tsr_checker #(
    parameter int WINDOW = 64
) (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_strobe,
    input wire logic       o_out_valid,
    input wire logic       o_stream_closed,
    input wire logic       o_run_last,
    input wire logic [6:0] o_pending_count
);

    // an accepted request starts work or answers at once
    `TSR_ASSERT_NEXT(a_accept_acts, i_clk, i_rst_n, i_rst_n && start && !busy, busy || o_strobe)

    // results of one request come in an unbroken burst
    `TSR_ASSERT_NEXT(a_burst_contig, i_clk, i_rst_n, o_strobe && !o_run_last, o_strobe)

    // a status result is the only result of its request
    `TSR_ASSERT_IMPLY(a_status_alone, i_clk, i_rst_n, o_strobe && !o_out_valid, o_run_last)

    // a closed stream holds nothing
    `TSR_ASSERT_IMPLY(a_closed_empty, i_clk, i_rst_n, o_strobe && o_stream_closed,
                      o_pending_count == 7'd0)

    // occupancy never exceeds the window
    `TSR_ASSERT_IMPLY(a_pending_max, i_clk, i_rst_n, o_strobe, o_pending_count <= 7'(WINDOW))

endmodule

bind tcp_stream_reassembler tsr_checker #(
    .WINDOW (WINDOW)
) u_tsr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_strobe        (o_strobe),
    .o_out_valid     (o_out_valid),
    .o_stream_closed (o_stream_closed),
    .o_run_last      (o_run_last),
    .o_pending_count (o_pending_count)
);

`default_nettype wire
